// ===== rtl/max_priority_queue_linear_scan_macros.svh =====
// assertion macros shared by the checker of the priority queue
`ifndef MAX_PRIORITY_QUEUE_LINEAR_SCAN_MACROS_SVH
`define MAX_PRIORITY_QUEUE_LINEAR_SCAN_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define MPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define MPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mpq_pkg.sv =====
// types and constants of the linear-scan priority queue
`default_nettype none

package mpq_pkg;

  localparam int OpW     = 2;
  localparam int PrioW   = 8;
  localparam int PayW    = 16;
  localparam int StatusW = 2;
  localparam int CountW  = 5;

  localparam logic [OpW-1:0] OpPush = 2'd0;
  localparam logic [OpW-1:0] OpPop  = 2'd1;
  localparam logic [OpW-1:0] OpPeek = 2'd2;

  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StFull  = 2'd1;
  localparam logic [StatusW-1:0] StEmpty = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [PrioW-1:0] priority_req;
    logic [PayW-1:0]  payload;
  } mpq_in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               is_empty;
    logic [PayW-1:0]    top_payload;
    logic [PrioW-1:0]   top_priority;
    logic [CountW-1:0]  entry_count;
  } mpq_out_t;

endpackage

`default_nettype wire

// ===== rtl/mpq_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none

module mpq_ram #(
  parameter int Width = 24,
  parameter int Depth = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                           wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output      logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/max_priority_queue_linear_scan.sv =====
// push, peek and a pop on an empty queue give their beat in the cycle after acceptance
// pop: one ram read per held entry through a single compare unit, then the drain
// and done states before its result beat; input is not ready meanwhile
// push and peek take one item a cycle, a pop takes no new item before its result beat;
// a new item is taken only when the output register is empty or its beat leaves
// reset: asynchronous, active low; the queue comes up empty, ram is not cleared
`default_nettype none

module max_priority_queue_linear_scan #(
  parameter int DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire mpq_pkg::mpq_in_t in_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      mpq_pkg::mpq_out_t out_data_o
);

  import mpq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = PrioW + PayW;

  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SScan  = 2'd1;
  localparam logic [1:0] SDrain = 2'd2;
  localparam logic [1:0] SDone  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [PrioW-1:0] top_prio_q, top_prio_d;
  logic [PayW-1:0]  top_pay_q, top_pay_d;
  logic [AW-1:0]    top_idx_q, top_idx_d;
  logic [AW-1:0]    scan_q, scan_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pend_idx_q, pend_idx_d;
  logic             best_vld_q, best_vld_d;
  logic [PrioW-1:0] best_prio_q, best_prio_d;
  logic [PayW-1:0]  best_pay_q, best_pay_d;
  logic [AW-1:0]    best_idx_q, best_idx_d;
  logic             out_valid_q, out_valid_d;
  mpq_out_t         out_q, out_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [EW-1:0]    ram_wdata;
  logic [EW-1:0]    ram_rdata;
  logic [PrioW-1:0] rd_prio;
  logic [PayW-1:0]  rd_pay;

  logic               out_free;
  logic               accept;
  logic               res_load;
  logic [StatusW-1:0] res_status;

  mpq_ram #(
    .Width (EW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_q),
    .rdata_o (ram_rdata)
  );

  assign rd_prio    = ram_rdata[EW-1:PayW];
  assign rd_pay     = ram_rdata[PayW-1:0];
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == SIdle) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    top_prio_d  = top_prio_q;
    top_pay_d   = top_pay_q;
    top_idx_d   = top_idx_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    pend_idx_d  = scan_q;
    best_vld_d  = best_vld_q;
    best_prio_d = best_prio_q;
    best_pay_d  = best_pay_q;
    best_idx_d  = best_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    res_load    = 1'b0;
    res_status  = StOk;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          case (in_data_i.op)
            OpPush: begin
              res_load = 1'b1;
              if (count_q == CW'(DEPTH)) begin
                res_status = StFull;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                ram_wdata = {in_data_i.priority_req, in_data_i.payload};
                count_d   = count_q + CW'(1);
                // strict compare keeps the older entry on a tie
                if (count_q == '0 || in_data_i.priority_req > top_prio_q) begin
                  top_prio_d = in_data_i.priority_req;
                  top_pay_d  = in_data_i.payload;
                  top_idx_d  = count_q[AW-1:0];
                end
              end
            end
            OpPop: begin
              if (count_q == '0) begin
                res_load   = 1'b1;
                res_status = StEmpty;
              end else begin
                state_d    = SScan;
                scan_d     = '0;
                best_vld_d = 1'b0;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      SScan: begin
        pend_d     = 1'b1;
        pend_idx_d = scan_q;
        if (CW'(scan_q) == count_q - CW'(1)) begin
          state_d = SDrain;
        end else begin
          scan_d = scan_q + AW'(1);
        end
      end
      SDrain: begin
        state_d = SDone;
      end
      SDone: begin
        if (out_free) begin
          res_load   = 1'b1;
          count_d    = count_q - CW'(1);
          top_prio_d = best_prio_q;
          top_pay_d  = best_pay_q;
          top_idx_d  = best_idx_q;
          state_d    = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    // one entry per cycle: skip the victim, close the gap, track the new top
    if (pend_q && pend_idx_q != top_idx_q) begin
      if (pend_idx_q > top_idx_q) begin
        ram_we    = 1'b1;
        ram_waddr = pend_idx_q - AW'(1);
        ram_wdata = ram_rdata;
      end
      if (!best_vld_q || rd_prio > best_prio_q) begin
        best_vld_d  = 1'b1;
        best_prio_d = rd_prio;
        best_pay_d  = rd_pay;
        best_idx_d  = (pend_idx_q > top_idx_q) ? pend_idx_q - AW'(1) : pend_idx_q;
      end
    end

    if (res_load) begin
      out_valid_d        = 1'b1;
      out_d.status       = res_status;
      out_d.is_empty     = (count_d == '0);
      out_d.top_payload  = (count_d == '0) ? '0 : top_pay_d;
      out_d.top_priority = (count_d == '0) ? '0 : top_prio_d;
      out_d.entry_count  = CountW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      pend_q      <= 1'b0;
      best_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      best_vld_q  <= best_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_prio_q  <= top_prio_d;
    top_pay_q   <= top_pay_d;
    top_idx_q   <= top_idx_d;
    scan_q      <= scan_d;
    pend_idx_q  <= pend_idx_d;
    best_prio_q <= best_prio_d;
    best_pay_q  <= best_pay_d;
    best_idx_q  <= best_idx_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/mpq_checker.sv =====
// port-level checker for the priority queue, bound to the top level
`default_nettype none

`include "max_priority_queue_linear_scan_macros.svh"

module mpq_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire mpq_pkg::mpq_out_t out_data_o
);

  import mpq_pkg::*;

  // a waiting result beat holds until taken
  `MPQ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result beat changed while stalled")

  // a new item is only taken when the output register can hold its result
  `MPQ_ASSERT_NOW(a_room_for_result, in_valid_i && in_ready_o && out_valid_o, out_ready_i, "item taken with output register blocked")

  `MPQ_ASSERT_NOW(a_empty_count, out_valid_o, out_data_o.is_empty == (out_data_o.entry_count == '0), "is_empty disagrees with count")

  `MPQ_ASSERT_NOW(a_empty_top_zero, out_valid_o && out_data_o.is_empty, out_data_o.top_payload == '0 && out_data_o.top_priority == '0, "top not zero on empty queue")

  `MPQ_ASSERT_NOW(a_status_code, out_valid_o, out_data_o.status == StOk || out_data_o.status == StFull || out_data_o.status == StEmpty, "bad status code")

endmodule

bind max_priority_queue_linear_scan mpq_checker u_mpq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
